>>> rtl/core/vasw_pkg.sv
// ----------------------------------------------------------------------------
// vasw_pkg
// Shared types, constants and the attenuation code table for the volume
// attenuator serial writer.
// ----------------------------------------------------------------------------
package vasw_pkg;

   // Command opcodes; the fourth code has no meaning and is dropped.
   typedef enum logic [1:0] {
      OP_SET_VOLUME = 2'd0,
      OP_MUTE       = 2'd1,
      OP_POWER_SAVE = 2'd2
   } op_type;

   localparam int          FRAME_BITS  = 16;
   localparam int          RUN_BITS    = 2 * FRAME_BITS;
   localparam int          BIT_IDX_W   = $clog2(RUN_BITS);
   localparam logic [4:0]  VOL_MAX     = 5'd31;
   localparam int          QUEUE_DEPTH = 2;

   // One classified request as it waits between front and back.
   typedef struct packed {
      logic [7:0] code;
      logic [4:0] vol;
      logic       idle_low;
   } cmd_type;

   // Volume step to attenuation code.
   function automatic logic [7:0] atten_code(input logic [4:0] step);
      logic [7:0] code;
      case (step)
         5'd0:  code = 8'd127;
         5'd1:  code = 8'd105;
         5'd2:  code = 8'd99;
         5'd3:  code = 8'd95;
         5'd4:  code = 8'd90;
         5'd5:  code = 8'd86;
         5'd6:  code = 8'd83;
         5'd7:  code = 8'd80;
         5'd8:  code = 8'd78;
         5'd9:  code = 8'd76;
         5'd10: code = 8'd74;
         5'd11: code = 8'd72;
         5'd12: code = 8'd71;
         5'd13: code = 8'd69;
         5'd14: code = 8'd68;
         5'd15: code = 8'd67;
         5'd16: code = 8'd60;
         5'd17: code = 8'd53;
         5'd18: code = 8'd48;
         5'd19: code = 8'd44;
         5'd20: code = 8'd41;
         5'd21: code = 8'd38;
         5'd22: code = 8'd36;
         5'd23: code = 8'd34;
         5'd24: code = 8'd27;
         5'd25: code = 8'd20;
         5'd26: code = 8'd15;
         5'd27: code = 8'd11;
         5'd28: code = 8'd8;
         5'd29: code = 8'd5;
         5'd30: code = 8'd3;
         5'd31: code = 8'd0;
         default: code = 8'd127;
      endcase
      return code;
   endfunction

endpackage

>>> rtl/core/vasw_front.sv
// ----------------------------------------------------------------------------
// vasw_front
// Accepts requests, drops the unused opcode, clamps the volume and looks up
// the attenuation code before pushing the command into the queue.
// ----------------------------------------------------------------------------
module vasw_front (
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [1:0]           req_opcode,
   input  logic signed [7:0]    req_volume,
   input  logic                 q_full,
   output logic                 push,
   output vasw_pkg::cmd_type    push_data
);
   import vasw_pkg::*;

   logic [4:0] clamped;
   logic [4:0] step;
   logic       known_op;
   logic       idle_low;

   // The queue being full is the only reason to hold a request back.
   assign req_stall = q_full;

   // Negative requests go to step 0, anything above the top step saturates.
   always_comb begin
      if (req_volume[7]) begin
         clamped = 5'd0;
      end else if (req_volume[6:5] != 2'b00) begin
         clamped = VOL_MAX;
      end else begin
         clamped = req_volume[4:0];
      end
   end

   // Classify the opcode; mute and power save both apply step 0.
   always_comb begin
      case (req_opcode)
         OP_SET_VOLUME: begin
            known_op = 1'b1;
            step     = clamped;
            idle_low = 1'b0;
         end
         OP_MUTE: begin
            known_op = 1'b1;
            step     = 5'd0;
            idle_low = 1'b0;
         end
         OP_POWER_SAVE: begin
            known_op = 1'b1;
            step     = 5'd0;
            idle_low = 1'b1;
         end
         default: begin
            known_op = 1'b0;
            step     = 5'd0;
            idle_low = 1'b0;
         end
      endcase
   end

   // Only meaningful requests enter the queue.
   assign push               = req_valid && !req_stall && known_op;
   assign push_data.code     = atten_code(step);
   assign push_data.vol      = step;
   assign push_data.idle_low = idle_low;

endmodule

>>> rtl/core/vasw_queue.sv
// ----------------------------------------------------------------------------
// vasw_queue
// Short first-in first-out queue of classified commands between the front
// and the serial back end.
// ----------------------------------------------------------------------------
module vasw_queue #(
   parameter int QueueDepth = vasw_pkg::QUEUE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  vasw_pkg::cmd_type    push_data,
   input  logic                 pop,
   output logic                 full,
   output logic                 head_valid,
   output vasw_pkg::cmd_type    head_data
);
   import vasw_pkg::*;

   localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int CntW = $clog2(QueueDepth + 1);
   localparam logic [PtrW-1:0] PtrLast = PtrW'(QueueDepth - 1);
   localparam logic [CntW-1:0] CntFull = CntW'(QueueDepth);

   cmd_type         entry_ff [QueueDepth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            do_push;
   logic            do_pop;

   assign full       = (count_ff == CntFull);
   assign head_valid = (count_ff != '0);
   assign head_data  = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   // Pointer and fill count updates, wrapping at the depth.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrLast) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrLast) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> rtl/core/vasw_back.sv
// ----------------------------------------------------------------------------
// vasw_back
// Serialiser: takes one command from the queue and shifts out two 16-bit
// frames, one bit per response, through a registered output stage.
// ----------------------------------------------------------------------------
module vasw_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 head_valid,
   input  vasw_pkg::cmd_type    head_data,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_data_bit,
   output logic                 rsp_channel,
   output logic                 rsp_frame_end,
   output logic                 rsp_last,
   output logic [4:0]           rsp_applied_volume,
   output logic                 rsp_pins_idle_low
);
   import vasw_pkg::*;

   localparam logic [BIT_IDX_W-1:0] LastIdx = BIT_IDX_W'(RUN_BITS - 1);

   logic                 busy_ff, busy_in;
   logic [BIT_IDX_W-1:0] bit_idx_ff, bit_idx_in;
   cmd_type              cmd_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 data_bit_ff, data_bit_in;
   logic                 channel_ff, channel_in;
   logic                 frame_end_ff, frame_end_in;
   logic                 last_ff, last_in;
   logic [4:0]           vol_ff;
   logic                 idle_low_ff;

   logic                 load;
   logic                 active;
   cmd_type              cur;
   logic [3:0]           k;

   // The output stage takes a new bit when empty or when its bit leaves.
   assign load   = !rsp_valid_ff || !rsp_stall;
   assign active = busy_ff || head_valid;
   assign cur    = busy_ff ? cmd_ff : head_data;
   assign pop    = load && !busy_ff && head_valid;
   assign k      = bit_idx_ff[3:0];

   // Frame layout: six zeros, channel selector high then low bit, code MSB first.
   always_comb begin
      channel_in   = bit_idx_ff[BIT_IDX_W-1];
      frame_end_in = (k == 4'd15);
      last_in      = (bit_idx_ff == LastIdx);
      if (k < 4'd7) begin
         data_bit_in = 1'b0;
      end else if (k == 4'd7) begin
         data_bit_in = channel_in;
      end else begin
         data_bit_in = cur.code[~k[2:0]];
      end
   end

   // Run sequencing and output valid.
   always_comb begin
      busy_in      = busy_ff;
      bit_idx_in   = bit_idx_ff;
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = active;
         if (active) begin
            bit_idx_in = bit_idx_ff + 1'b1;
            busy_in    = !last_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         bit_idx_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         bit_idx_ff   <= bit_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Command and output payload registers.
   always_ff @(posedge clock) begin
      if (pop) begin
         cmd_ff <= head_data;
      end
      if (load && active) begin
         data_bit_ff  <= data_bit_in;
         channel_ff   <= channel_in;
         frame_end_ff <= frame_end_in;
         last_ff      <= last_in;
         vol_ff       <= cur.vol;
         idle_low_ff  <= cur.idle_low;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_data_bit       = data_bit_ff;
   assign rsp_channel        = channel_ff;
   assign rsp_frame_end      = frame_end_ff;
   assign rsp_last           = last_ff;
   assign rsp_applied_volume = vol_ff;
   assign rsp_pins_idle_low  = idle_low_ff;

endmodule

>>> rtl/core/volume_attenuator_serial_writer.sv
// ----------------------------------------------------------------------------
// volume_attenuator_serial_writer
// Top level of the serial loader for a two-channel volume attenuator.
// ----------------------------------------------------------------------------
// Each accepted request (set volume, mute or power save) produces 32
// responses, one serial bit each: a 16-bit frame for the left channel and
// then one for the right, each six zeros, a two-bit channel selector and the
// 8-bit attenuation code, most significant bit first. Requests with the
// unused opcode are accepted and produce nothing. The serialiser emits one
// bit per cycle while a run is active and rsp_stall is low; the back end
// moves from the last bit of one run to the first bit of the next without
// a gap. A small queue between the classifying front end and the serialiser
// lets requests be accepted while a run is still being shifted out, and
// req_stall rises only when that queue is full.
// ----------------------------------------------------------------------------
module volume_attenuator_serial_writer #(
   parameter int QueueDepth = vasw_pkg::QUEUE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [1:0]           req_opcode,
   input  logic signed [7:0]    req_volume,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_data_bit,
   output logic                 rsp_channel,
   output logic                 rsp_frame_end,
   output logic                 rsp_last,
   output logic [4:0]           rsp_applied_volume,
   output logic                 rsp_pins_idle_low
);
   import vasw_pkg::*;

   logic    push;
   cmd_type push_data;
   logic    q_full;
   logic    pop;
   logic    head_valid;
   cmd_type head_data;

   // Front end: acceptance and classification.
   vasw_front u_front (
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_opcode (req_opcode),
      .req_volume (req_volume),
      .q_full     (q_full),
      .push       (push),
      .push_data  (push_data)
   );

   // Command queue between front and back.
   vasw_queue #(
      .QueueDepth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_data),
      .pop        (pop),
      .full       (q_full),
      .head_valid (head_valid),
      .head_data  (head_data)
   );

   // Back end: serialiser and output register.
   vasw_back u_back (
      .clock              (clock),
      .reset              (reset),
      .head_valid         (head_valid),
      .head_data          (head_data),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_data_bit       (rsp_data_bit),
      .rsp_channel        (rsp_channel),
      .rsp_frame_end      (rsp_frame_end),
      .rsp_last           (rsp_last),
      .rsp_applied_volume (rsp_applied_volume),
      .rsp_pins_idle_low  (rsp_pins_idle_low)
   );

   // A run, once started, delivers its bits without a gap.
   a_run_continuous: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last |=> rsp_valid)
      else $error("gap inside a serial run");

   // The applied volume does not change within a run.
   a_run_volume_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last |=> $stable(rsp_applied_volume))
      else $error("applied volume changed within a run");

   // Power save always applies the lowest step.
   a_power_save_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_pins_idle_low |-> rsp_applied_volume == 5'd0)
      else $error("power save with non-zero volume step");

   // The final bit of a run closes the right-channel frame.
   a_last_closes_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_frame_end && rsp_channel)
      else $error("run ended outside the right-channel frame end");

endmodule

>>> tb/vasw_checker.sv
// ----------------------------------------------------------------------------
// vasw_checker
// Watches both channels of the volume attenuator serial writer, works out
// the 32 serial bits that each accepted request with a used opcode must
// produce and compares every accepted response with the oldest bit still outstanding.
// ----------------------------------------------------------------------------
module vasw_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  logic [1:0]        req_opcode,
   input  logic signed [7:0] req_volume,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  logic              rsp_data_bit,
   input  logic              rsp_channel,
   input  logic              rsp_frame_end,
   input  logic              rsp_last,
   input  logic [4:0]        rsp_applied_volume,
   input  logic              rsp_pins_idle_low,
   output int                fail_count,
   output int                pending_bits
);
   import vasw_pkg::*;

   // One serial bit as it should appear on the response channel.
   typedef struct packed {
      logic       data_bit;
      logic       channel;
      logic       frame_end;
      logic       last;
      logic [4:0] applied_volume;
      logic       pins_idle_low;
   } serial_bit_type;

   // Attenuation code for each volume step, loudest step last.
   localparam logic [7:0] STEP_TO_CODE [32] = '{
      8'd127, 8'd105, 8'd99, 8'd95, 8'd90, 8'd86, 8'd83, 8'd80,
      8'd78,  8'd76,  8'd74, 8'd72, 8'd71, 8'd69, 8'd68, 8'd67,
      8'd60,  8'd53,  8'd48, 8'd44, 8'd41, 8'd38, 8'd36, 8'd34,
      8'd27,  8'd20,  8'd15, 8'd11, 8'd8,  8'd5,  8'd3,  8'd0
   };

   serial_bit_type expected_bits[$];

   // Negative requests give step 0 and anything above the top step gives 31.
   function automatic logic [4:0] clamp_step(input logic signed [7:0] vol);
      if (vol < 0)
         return 5'd0;
      if (vol > $signed({3'b000, VOL_MAX}))
         return VOL_MAX;
      return vol[4:0];
   endfunction

   // Queues the two frames that one request expands into.
   task automatic expand_request(input logic [1:0] op, input logic signed [7:0] vol);
      logic [4:0]     step;
      logic [7:0]     code;
      logic           idle_low;
      logic           ch;
      int             k;
      serial_bit_type b;
      case (op)
         OP_SET_VOLUME: begin
            step     = clamp_step(vol);
            idle_low = 1'b0;
         end
         OP_MUTE: begin
            step     = 5'd0;
            idle_low = 1'b0;
         end
         OP_POWER_SAVE: begin
            step     = 5'd0;
            idle_low = 1'b1;
         end
         default: begin
            // The unused opcode is swallowed without any response.
            return;
         end
      endcase
      code = STEP_TO_CODE[step];
      for (int i = 0; i < RUN_BITS; i++) begin
         ch = (i >= FRAME_BITS);
         k  = i % FRAME_BITS;
         if (k < 6)
            b.data_bit = 1'b0;
         else if (k == 6)
            b.data_bit = 1'b0;
         else if (k == 7)
            b.data_bit = ch;
         else
            b.data_bit = code[15 - k];
         b.channel        = ch;
         b.frame_end      = (k == FRAME_BITS - 1);
         b.last           = (i == RUN_BITS - 1);
         b.applied_volume = step;
         b.pins_idle_low  = idle_low;
         expected_bits.push_back(b);
      end
   endtask

   // Prints one field that differs from its prediction.
   task automatic report_field(input string field, input int want, input int got);
      fail_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
   endtask

   // Sample both channels at the rising edge, before the block updates.
   always @(posedge clock) begin
      serial_bit_type want;
      if (reset) begin
         expected_bits.delete();
      end else begin
         if (req_valid && !req_stall)
            expand_request(req_opcode, req_volume);
         if (rsp_valid && !rsp_stall) begin
            if (expected_bits.size() == 0) begin
               fail_count++;
               $display("%0t: response with nothing outstanding, expected none, actual %b",
                        $time, {rsp_data_bit, rsp_channel, rsp_frame_end, rsp_last,
                                rsp_applied_volume, rsp_pins_idle_low});
            end else begin
               want = expected_bits.pop_front();
               if (rsp_data_bit !== want.data_bit)
                  report_field("data_bit", want.data_bit, rsp_data_bit);
               if (rsp_channel !== want.channel)
                  report_field("channel", want.channel, rsp_channel);
               if (rsp_frame_end !== want.frame_end)
                  report_field("frame_end", want.frame_end, rsp_frame_end);
               if (rsp_last !== want.last)
                  report_field("last", want.last, rsp_last);
               if (rsp_applied_volume !== want.applied_volume)
                  report_field("applied_volume", want.applied_volume, rsp_applied_volume);
               if (rsp_pins_idle_low !== want.pins_idle_low)
                  report_field("pins_idle_low", want.pins_idle_low, rsp_pins_idle_low);
            end
         end
      end
      pending_bits = expected_bits.size();
   end

   initial begin
      fail_count   = 0;
      pending_bits = 0;
   end

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the volume attenuator serial writer. Directed
// requests cover the clamping limits and every opcode, then random requests
// follow with random gaps and response stalls, one long response hold-off
// and one pause until the block has drained. A separate checker predicts
// and compares every serial bit.
// ----------------------------------------------------------------------------
module tb_top;
   import vasw_pkg::*;

   // The fourth opcode value has no meaning and yields no response.
   localparam logic [1:0] OP_IGNORED    = 2'd3;
   localparam int         RANDOM_ITEMS  = 400;
   localparam int         PHASE_ITEMS   = 40;
   localparam int         LONG_HOLD     = 400;
   localparam int         DRAIN_CYCLES  = 80;
   localparam int         CYCLE_LIMIT   = 1000000;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic [1:0]        req_opcode;
   logic signed [7:0] req_volume;
   logic              rsp_valid;
   logic              rsp_stall;
   logic              rsp_data_bit;
   logic              rsp_channel;
   logic              rsp_frame_end;
   logic              rsp_last;
   logic [4:0]        rsp_applied_volume;
   logic              rsp_pins_idle_low;

   int                fail_count;
   int                pending_bits;
   int                cycle_count;
   bit                sender_quiet;
   bit                receiver_quiet;
   bit                long_hold_pending;

   volume_attenuator_serial_writer dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_opcode         (req_opcode),
      .req_volume         (req_volume),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_data_bit       (rsp_data_bit),
      .rsp_channel        (rsp_channel),
      .rsp_frame_end      (rsp_frame_end),
      .rsp_last           (rsp_last),
      .rsp_applied_volume (rsp_applied_volume),
      .rsp_pins_idle_low  (rsp_pins_idle_low)
   );

   vasw_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_opcode         (req_opcode),
      .req_volume         (req_volume),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_data_bit       (rsp_data_bit),
      .rsp_channel        (rsp_channel),
      .rsp_frame_end      (rsp_frame_end),
      .rsp_last           (rsp_last),
      .rsp_applied_volume (rsp_applied_volume),
      .rsp_pins_idle_low  (rsp_pins_idle_low),
      .fail_count         (fail_count),
      .pending_bits       (pending_bits)
   );

   // Free-running clock with a period of 10.
   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Offers one request after a random gap and holds it until accepted.
   task automatic send_request(input logic [1:0] op, input logic signed [7:0] vol);
      int gap;
      gap = sender_quiet ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid  <= 1'b1;
      req_opcode <= op;
      req_volume <= vol;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   // Volumes lean towards the table range, with the extremes mixed in.
   function automatic logic signed [7:0] random_volume();
      logic signed [7:0] v;
      case ($urandom_range(0, 3))
         0, 1: v = 8'($urandom_range(0, 31));
         2: v = 8'($urandom);
         default: begin
            case ($urandom_range(0, 4))
               0: v = -8'sd128;
               1: v = -8'sd1;
               2: v = 8'sd31;
               3: v = 8'sd32;
               default: v = 8'sd127;
            endcase
         end
      endcase
      return v;
   endfunction

   // Mostly set-volume requests, with mute, power save and the unused code.
   function automatic logic [1:0] random_opcode();
      int r;
      r = $urandom_range(0, 9);
      if (r < 7)
         return OP_SET_VOLUME;
      if (r == 7)
         return OP_MUTE;
      if (r == 8)
         return OP_POWER_SAVE;
      return OP_IGNORED;
   endfunction

   // Response side: a random stall before each response, or a long one.
   initial begin
      int hold;
      rsp_stall = 1'b0;
      forever begin
         if (long_hold_pending) begin
            hold = LONG_HOLD;
            long_hold_pending = 1'b0;
         end else if (receiver_quiet) begin
            hold = 0;
         end else begin
            hold = $urandom_range(0, 8);
         end
         @(negedge clock);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // Cycle counter guarding against a hang.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb_top NOT OK");
      $finish;
   end

   // Reset, directed requests, random requests, then drain and verdict.
   initial begin
      req_valid         = 1'b0;
      req_opcode        = OP_SET_VOLUME;
      req_volume        = 8'sd0;
      reset             = 1'b1;
      sender_quiet      = 1'b0;
      receiver_quiet    = 1'b0;
      long_hold_pending = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Clamping limits and the table ends.
      send_request(OP_SET_VOLUME, -8'sd128);
      send_request(OP_SET_VOLUME, -8'sd1);
      send_request(OP_SET_VOLUME, 8'sd0);
      send_request(OP_SET_VOLUME, 8'sd1);
      send_request(OP_SET_VOLUME, 8'sd30);
      send_request(OP_SET_VOLUME, 8'sd31);
      send_request(OP_SET_VOLUME, 8'sd32);
      send_request(OP_SET_VOLUME, 8'sd127);
      send_request(OP_SET_VOLUME, 8'sd16);
      // Mute and power save ignore the volume field.
      send_request(OP_MUTE, 8'sd127);
      send_request(OP_MUTE, -8'sd128);
      send_request(OP_POWER_SAVE, 8'sd31);
      send_request(OP_POWER_SAVE, -8'sd1);
      // The unused opcode between runs and back to back.
      send_request(OP_IGNORED, 8'sd31);
      send_request(OP_SET_VOLUME, 8'sd15);
      send_request(OP_IGNORED, -8'sd128);
      send_request(OP_IGNORED, 8'sd127);
      send_request(OP_SET_VOLUME, 8'sd24);
      send_request(OP_POWER_SAVE, 8'sd0);
      send_request(OP_SET_VOLUME, 8'sd31);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         // New idling mix for each phase, some phases without any gaps.
         if (n % PHASE_ITEMS == 0) begin
            sender_quiet   = ($urandom_range(0, 3) == 0);
            receiver_quiet = ($urandom_range(0, 3) == 0);
         end
         // Hold the response side off while requests keep coming.
         if (n == 120) begin
            long_hold_pending = 1'b1;
            sender_quiet      = 1'b1;
         end
         if (n == 130)
            sender_quiet = 1'b0;
         // Let the block drain completely before carrying on.
         if (n == 250) begin
            req_valid <= 1'b0;
            while (pending_bits != 0) @(posedge clock);
            @(negedge clock);
         end
         send_request(random_opcode(), random_volume());
      end
      req_valid <= 1'b0;

      // Wait for the last runs to come out, then a margin for stray bits.
      while (pending_bits != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0 && pending_bits == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule

>>> sim.f
rtl/core/vasw_pkg.sv
rtl/core/vasw_front.sv
rtl/core/vasw_queue.sv
rtl/core/vasw_back.sv
rtl/core/volume_attenuator_serial_writer.sv
tb/vasw_checker.sv
tb/tb_top.sv
